@@ rtl/nearest_neighbor_downscaler_assert.svh @@
// Assertion macros shared by the downscaler RTL modules.
// No dependencies; included by the modules that carry checks.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_ASSERT_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define NND_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("downscaler check failed");

// cond must hold at every clock edge outside reset.
`define NND_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("downscaler invariant failed");

`endif

@@ rtl/dscl_pkg.sv @@
// Shared constants and types of the nearest-neighbor downscaler.
// No dependencies; every RTL module refers to it by scoped names.
package dscl_pkg;

    localparam int OUT_WIDTH  = 100;
    localparam int MAX_SIDE   = 4096;
    localparam int PIX_W      = 32;
    localparam int IDX_W      = 19;
    localparam int CFG_W      = 13;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int SCOL_W     = $clog2(MAX_SIDE);
    localparam int DCOL_W     = $clog2(OUT_WIDTH + 1);
    localparam int COLR_W     = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int DIVN_W     = $clog2(MAX_SIDE * OUT_WIDTH + 1);
    localparam int DIVC_W     = $clog2(DIVN_W + 1);
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;
    localparam int REG_IDX_W  = 1;
    localparam int OUT_DATA_W = ((PIX_W + IDX_W + 7) / 8) * 8;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [SIDE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quotient;
        logic [SIDE_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [PIX_W-1:0]  pixel;
        logic [SIDE_W-1:0] dest_height;
        logic [SIDE_W-1:0] row_step_q;
        logic [SIDE_W-1:0] row_step_r;
    } q_entry_t;

    typedef struct packed {
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] col_q;
        logic [COLR_W-1:0] col_r;
    } col_cfg_t;

endpackage

@@ rtl/dscl_div.sv @@
// Restoring divider, one quotient bit per cycle, for the frame setup.
// Depends on dscl_pkg for widths and the request/response structs.
module dscl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dscl_pkg::div_req_t req,
    output dscl_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [dscl_pkg::DIVC_W-1:0]   cnt_reg;
    logic [dscl_pkg::DIVN_W-1:0]   quo_reg;
    logic [dscl_pkg::SIDE_W-1:0]   rem_reg;
    logic [dscl_pkg::SIDE_W-1:0]   dvs_reg;
    logic [dscl_pkg::SIDE_W:0]     rem_shift;
    logic [dscl_pkg::SIDE_W:0]     rem_sub;
    logic                          fits;

    assign rem_shift = {rem_reg, quo_reg[dscl_pkg::DIVN_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == dscl_pkg::DIVC_W'(dscl_pkg::DIVN_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[dscl_pkg::DIVN_W-2:0], fits};
            rem_reg <= rem_sub[dscl_pkg::SIDE_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ rtl/dscl_front.sv @@
// Input side: accepts source beats and works out the frame geometry.
// Depends on dscl_pkg and dscl_div; feeds the queue read by dscl_back.
`include "nearest_neighbor_downscaler_assert.svh"

module dscl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dscl_pkg::PIX_W-1:0]  s_tdata,
    input  logic                        s_tuser,
    input  logic [dscl_pkg::SIDE_W-1:0] width,
    input  logic [dscl_pkg::SIDE_W-1:0] height,
    input  logic                        q_full,
    output logic                        q_push,
    output dscl_pkg::q_entry_t          q_entry
);

    typedef enum logic [3:0] {
        F_RUN  = 4'b0001,
        F_DIV1 = 4'b0010,
        F_DIV2 = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t                 state_reg, state_next;
    logic [dscl_pkg::PIX_W-1:0]   pix_reg, pix_next;
    logic [dscl_pkg::SIDE_W-1:0]  dh_reg, dh_next;
    logic [dscl_pkg::SIDE_W-1:0]  rq_reg, rq_next;
    logic [dscl_pkg::SIDE_W-1:0]  rr_reg, rr_next;
    dscl_pkg::div_req_t           div_req;
    dscl_pkg::div_rsp_t           div_rsp;

    dscl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == F_RUN) && !q_full;

    always_comb
    begin
        state_next       = state_reg;
        pix_next         = pix_reg;
        dh_next          = dh_reg;
        rq_next          = rq_reg;
        rr_next          = rr_reg;
        div_req.start    = 1'b0;
        div_req.dividend = dscl_pkg::DIVN_W'(height * dscl_pkg::OUT_WIDTH);
        div_req.divisor  = width;
        q_push           = 1'b0;
        q_entry.start       = 1'b0;
        q_entry.pixel       = s_tdata;
        q_entry.dest_height = dh_reg;
        q_entry.row_step_q  = rq_reg;
        q_entry.row_step_r  = rr_reg;
        case (state_reg)
            F_RUN:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (s_tuser)
                    begin
                        // First beat of a frame waits here for its geometry.
                        pix_next      = s_tdata;
                        div_req.start = 1'b1;
                        state_next    = F_DIV1;
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
            end
            F_DIV1:
            begin
                if (div_rsp.done)
                begin
                    dh_next = div_rsp.quotient[dscl_pkg::SIDE_W-1:0];
                    if (div_rsp.quotient == '0)
                    begin
                        rq_next    = '0;
                        rr_next    = '0;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = dscl_pkg::DIVN_W'(height);
                        div_req.divisor  = div_rsp.quotient[dscl_pkg::SIDE_W-1:0];
                        state_next       = F_DIV2;
                    end
                end
            end
            F_DIV2:
            begin
                if (div_rsp.done)
                begin
                    rq_next    = div_rsp.quotient[dscl_pkg::SIDE_W-1:0];
                    rr_next    = div_rsp.remainder;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                q_entry.start = 1'b1;
                q_entry.pixel = pix_reg;
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_RUN;
                end
            end
            default:
            begin
                state_next = F_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        dh_reg  <= dh_next;
        rq_reg  <= rq_next;
        rr_reg  <= rr_next;
    end

    `NND_ASSERT_IMP(a_push_not_full, clk, rst_n, q_push, !q_full)
    `NND_ASSERT_IMP(a_div_divisor_nonzero, clk, rst_n, div_req.start, div_req.divisor != '0)

endmodule

@@ rtl/dscl_queue.sv @@
// Short FIFO that decouples the input side from the output side.
// Depends on dscl_pkg for the entry type and depth.
module dscl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dscl_pkg::q_entry_t entry_in,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output dscl_pkg::q_entry_t entry_out
);

    dscl_pkg::q_entry_t           mem [dscl_pkg::Q_DEPTH];
    logic [dscl_pkg::Q_AW-1:0]    wr_ptr_reg;
    logic [dscl_pkg::Q_AW-1:0]    rd_ptr_reg;
    logic [dscl_pkg::Q_AW:0]      count_reg;

    assign full      = count_reg == (dscl_pkg::Q_AW + 1)'(dscl_pkg::Q_DEPTH);
    assign valid     = count_reg != '0;
    assign entry_out = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/dscl_back.sv @@
// Output side: tracks source and destination coordinates and emits pixels.
// Depends on dscl_pkg; reads entries from dscl_queue.
`include "nearest_neighbor_downscaler_assert.svh"

module dscl_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  dscl_pkg::q_entry_t              q_entry,
    output logic                            q_pop,
    input  dscl_pkg::col_cfg_t              col_cfg,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dscl_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int SW = dscl_pkg::SIDE_W;

    logic [dscl_pkg::SCOL_W-1:0] scol_reg, cur_scol;
    logic [SW-1:0]               srow_reg, cur_srow;
    logic [dscl_pkg::DCOL_W-1:0] dcol_reg, cur_dcol;
    logic [SW-1:0]               drow_reg, cur_drow;
    logic [SW-1:0]               dh_reg, cur_dh;
    logic [SW-1:0]               ctgt_reg, cur_ctgt;
    logic [dscl_pkg::COLR_W-1:0] crem_reg, cur_crem;
    logic [SW-1:0]               rtgt_reg, cur_rtgt;
    logic [SW-1:0]               rrem_reg, cur_rrem;
    logic [SW-1:0]               rsq_reg, cur_rsq;
    logic [SW-1:0]               rsr_reg, cur_rsr;

    logic [dscl_pkg::SCOL_W-1:0] scol_next;
    logic [SW-1:0]               srow_next, drow_next, ctgt_next, rtgt_next, rrem_next;
    logic [dscl_pkg::DCOL_W-1:0] dcol_next;
    logic [dscl_pkg::COLR_W-1:0] crem_next;

    logic                        active, on_row, emit, row_end, last;
    logic [dscl_pkg::COLR_W:0]   cr_sum;
    logic                        cr_wrap;
    logic [SW:0]                 rr_sum;
    logic                        rr_wrap;
    logic [dscl_pkg::IDX_W-1:0]  idx;

    logic                        out_valid_reg;
    logic [dscl_pkg::PIX_W-1:0]  out_pixel_reg;
    logic [dscl_pkg::IDX_W-1:0]  out_index_reg;
    logic                        out_last_reg;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    // A frame-start beat restarts every counter before it is classified.
    always_comb
    begin
        if (q_entry.start)
        begin
            cur_scol = '0;
            cur_srow = '0;
            cur_dcol = '0;
            cur_drow = '0;
            cur_ctgt = '0;
            cur_crem = '0;
            cur_rtgt = '0;
            cur_rrem = '0;
            cur_dh   = q_entry.dest_height;
            cur_rsq  = q_entry.row_step_q;
            cur_rsr  = q_entry.row_step_r;
        end
        else
        begin
            cur_scol = scol_reg;
            cur_srow = srow_reg;
            cur_dcol = dcol_reg;
            cur_drow = drow_reg;
            cur_ctgt = ctgt_reg;
            cur_crem = crem_reg;
            cur_rtgt = rtgt_reg;
            cur_rrem = rrem_reg;
            cur_dh   = dh_reg;
            cur_rsq  = rsq_reg;
            cur_rsr  = rsr_reg;
        end
    end

    assign active  = cur_drow < cur_dh;
    assign on_row  = active && (cur_srow == cur_rtgt);
    assign emit    = on_row && (cur_dcol < dscl_pkg::DCOL_W'(dscl_pkg::OUT_WIDTH))
                     && (SW'(cur_scol) == cur_ctgt);
    assign row_end = (SW'(cur_scol) + SW'(1)) >= col_cfg.width;
    assign idx     = dscl_pkg::IDX_W'(cur_dcol)
                     + dscl_pkg::IDX_W'(cur_drow * dscl_pkg::OUT_WIDTH);
    assign last    = (({1'b0, cur_drow} + (SW + 1)'(1)) == {1'b0, cur_dh})
                     && ((cur_dcol + 1'b1) == dscl_pkg::DCOL_W'(dscl_pkg::OUT_WIDTH));

    assign cr_sum  = {1'b0, cur_crem} + {1'b0, col_cfg.col_r};
    assign cr_wrap = cr_sum >= (dscl_pkg::COLR_W + 1)'(dscl_pkg::OUT_WIDTH);
    assign rr_sum  = {1'b0, cur_rrem} + {1'b0, cur_rsr};
    assign rr_wrap = rr_sum >= {1'b0, cur_dh};

    always_comb
    begin
        scol_next = cur_scol;
        srow_next = cur_srow;
        dcol_next = cur_dcol;
        drow_next = cur_drow;
        ctgt_next = cur_ctgt;
        crem_next = cur_crem;
        rtgt_next = cur_rtgt;
        rrem_next = cur_rrem;
        if (emit)
        begin
            dcol_next = cur_dcol + 1'b1;
            ctgt_next = cur_ctgt + col_cfg.col_q + SW'(cr_wrap);
            crem_next = cr_wrap
                        ? dscl_pkg::COLR_W'(cr_sum - (dscl_pkg::COLR_W + 1)'(dscl_pkg::OUT_WIDTH))
                        : cr_sum[dscl_pkg::COLR_W-1:0];
        end
        if (row_end)
        begin
            scol_next = '0;
            dcol_next = '0;
            ctgt_next = '0;
            crem_next = '0;
            if (active)
            begin
                srow_next = cur_srow + 1'b1;
                if (on_row)
                begin
                    drow_next = cur_drow + 1'b1;
                    rtgt_next = cur_rtgt + cur_rsq + SW'(rr_wrap);
                    rrem_next = rr_wrap ? SW'(rr_sum - {1'b0, cur_dh}) : rr_sum[SW-1:0];
                end
            end
        end
        else
        begin
            scol_next = cur_scol + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg      <= '0;
            srow_reg      <= '0;
            dcol_reg      <= '0;
            drow_reg      <= '0;
            dh_reg        <= '0;
            ctgt_reg      <= '0;
            crem_reg      <= '0;
            rtgt_reg      <= '0;
            rrem_reg      <= '0;
            rsq_reg       <= '0;
            rsr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            scol_reg      <= scol_next;
            srow_reg      <= srow_next;
            dcol_reg      <= dcol_next;
            drow_reg      <= drow_next;
            dh_reg        <= cur_dh;
            ctgt_reg      <= ctgt_next;
            crem_reg      <= crem_next;
            rtgt_reg      <= rtgt_next;
            rrem_reg      <= rrem_next;
            rsq_reg       <= cur_rsq;
            rsr_reg       <= cur_rsr;
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_pixel_reg <= q_entry.pixel;
            out_index_reg <= idx;
            out_last_reg  <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dscl_pkg::OUT_DATA_W'({out_index_reg, out_pixel_reg});
    assign m_tlast  = out_last_reg;

    `NND_ASSERT_ALWAYS(a_col_rem_range, clk, rst_n, crem_reg < dscl_pkg::OUT_WIDTH)
    `NND_ASSERT_IMP(a_row_rem_range, clk, rst_n, dh_reg != '0, rrem_reg < dh_reg)
    `NND_ASSERT_IMP(a_last_index, clk, rst_n, out_valid_reg && out_last_reg, out_index_reg == dscl_pkg::IDX_W'(dh_reg * dscl_pkg::OUT_WIDTH - 1))

endmodule

@@ rtl/nearest_neighbor_downscaler.sv @@
// A selected pixel passes through the queue and the output register on its way to m_tdata.
// Throughput: one source beat per cycle while the queue has room, except at a frame
// start, where the start beat holds the input while the shared bit-serial divider
// does its work (one division when the output height is zero, two otherwise).
// Reset clears all counters and the queue; no pixel is emitted until a start beat
// arrives, and the size registers return to 640 by 480.
module nearest_neighbor_downscaler (
    input  logic                               clk,
    input  logic                               rst_n,
    // Source stream. tdata: src_pixel[31:0]. tuser: start_frame.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dscl_pkg::PIX_W-1:0]         s_tdata,
    input  logic                               s_tuser,
    // Result stream. tdata: out_pixel[31:0], out_index[50:32], zero pad above.
    // tlast: frame_done.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dscl_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    // Register write channel: index 0 is src_width, index 1 is src_height.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dscl_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [dscl_pkg::CFG_W-1:0]         cfg_data
);

    // The column step is w / OUT_WIDTH, taken by a reciprocal multiply. The shift
    // is wide enough that the rounding error never reaches the next integer for
    // any width up to MAX_SIDE.
    localparam int RECIP_SHIFT = dscl_pkg::DIVN_W + 1;
    localparam int PROD_W      = RECIP_SHIFT + dscl_pkg::SIDE_W;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + dscl_pkg::OUT_WIDTH - 1)
                                 / dscl_pkg::OUT_WIDTH;

    // Reset width, already raised to the output width and limited to the largest side.
    localparam int RESET_EFF_W =
        (dscl_pkg::RESET_WIDTH < dscl_pkg::OUT_WIDTH) ? dscl_pkg::OUT_WIDTH :
        (dscl_pkg::RESET_WIDTH > dscl_pkg::MAX_SIDE)  ? dscl_pkg::MAX_SIDE  :
        dscl_pkg::RESET_WIDTH;
    localparam int RESET_EFF_H =
        (dscl_pkg::RESET_HEIGHT > dscl_pkg::MAX_SIDE) ? dscl_pkg::MAX_SIDE :
        dscl_pkg::RESET_HEIGHT;

    // The registers hold the effective sizes, so the datapath never clamps.
    logic [dscl_pkg::SIDE_W-1:0] width_reg;
    logic [dscl_pkg::SIDE_W-1:0] height_reg;
    logic [dscl_pkg::SIDE_W-1:0] col_q_reg;
    logic [dscl_pkg::COLR_W-1:0] col_r_reg;

    logic [dscl_pkg::SIDE_W-1:0] eff_w;
    logic [dscl_pkg::SIDE_W-1:0] eff_h;
    logic [PROD_W-1:0]           recip_prod;
    logic [dscl_pkg::SIDE_W-1:0] new_col_q;
    logic [dscl_pkg::COLR_W-1:0] new_col_r;

    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    dscl_pkg::q_entry_t          q_in;
    dscl_pkg::q_entry_t          q_out;
    dscl_pkg::col_cfg_t          col_cfg;

    // Always taken; the user must let writes arrive only while the block is idle (unchecked).
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data < dscl_pkg::OUT_WIDTH)
        begin
            eff_w = dscl_pkg::SIDE_W'(dscl_pkg::OUT_WIDTH);
        end
        else if (cfg_data > dscl_pkg::MAX_SIDE)
        begin
            eff_w = dscl_pkg::SIDE_W'(dscl_pkg::MAX_SIDE);
        end
        else
        begin
            eff_w = dscl_pkg::SIDE_W'(cfg_data);
        end

        if (cfg_data > dscl_pkg::MAX_SIDE)
        begin
            eff_h = dscl_pkg::SIDE_W'(dscl_pkg::MAX_SIDE);
        end
        else
        begin
            eff_h = dscl_pkg::SIDE_W'(cfg_data);
        end
    end

    assign recip_prod = PROD_W'(eff_w) * PROD_W'(RECIP);
    assign new_col_q  = recip_prod[PROD_W-1:RECIP_SHIFT];
    assign new_col_r  = dscl_pkg::COLR_W'(eff_w - dscl_pkg::SIDE_W'(new_col_q
                                                      * dscl_pkg::OUT_WIDTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dscl_pkg::SIDE_W'(RESET_EFF_W);
            height_reg <= dscl_pkg::SIDE_W'(RESET_EFF_H);
            col_q_reg  <= dscl_pkg::SIDE_W'(RESET_EFF_W / dscl_pkg::OUT_WIDTH);
            col_r_reg  <= dscl_pkg::COLR_W'(RESET_EFF_W % dscl_pkg::OUT_WIDTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dscl_pkg::REG_SRC_WIDTH:
                begin
                    width_reg <= eff_w;
                    col_q_reg <= new_col_q;
                    col_r_reg <= new_col_r;
                end
                dscl_pkg::REG_SRC_HEIGHT:
                begin
                    height_reg <= eff_h;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign col_cfg.width = width_reg;
    assign col_cfg.col_q = col_q_reg;
    assign col_cfg.col_r = col_r_reg;

    // Front end: takes beats, and on a start beat runs the frame-size divisions.
    dscl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .width    (width_reg),
        .height   (height_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // Queue between the two halves; a start entry carries the new frame geometry.
    dscl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .entry_out (q_out)
    );

    // Back end: one entry per cycle unless stalled, through the coordinate counters into the
    // output register, which keeps draining while the next entry is classified.
    dscl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .col_cfg  (col_cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ dv/nearest_neighbor_downscaler_test.sv @@
// Self-checking testbench for the nearest-neighbor downscaler: streams source
// frames of random pixels, predicts every emitted pixel and checks the result stream.
// Depends on dscl_pkg and the nearest_neighbor_downscaler RTL.
module nearest_neighbor_downscaler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dscl_pkg::*;

    localparam int CLK_PERIOD      = 10;
    // Source beats in the random part; with the directed tests about 950 in all.
    localparam int RANDOM_BEATS    = 820;
    // Quiet time before a register write. A start beat with no selected pixel can
    // leave the divider busy after the owed pixels are drained, so wait for it to finish.
    localparam int SETTLE_CYCLES   = 2 * DIVN_W + 24;
    // Length of the receiver hold-off in the backpressure test.
    localparam int HOLD_OFF_CYCLES = 400;
    // Run limit in ns: even with a one-beat frame and two register writes for every
    // beat, a correct run finishes before this limit.
    localparam int RUN_LIMIT_NS    = 20_000_000;

    // One selected pixel as it should appear on the result stream.
    typedef struct packed {
        bit [PIX_W-1:0] pixel;
        bit [IDX_W-1:0] index;
        bit             done;
    } scaled_pixel_t;

    // How eagerly the result side takes beats while not held off.
    typedef enum int {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_pace_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // Pixels the block owes us, oldest first.
    scaled_pixel_t expected_pixels[$];
    scaled_pixel_t oldest_pixel;

    // Our own copy of the size registers and of the frame-walking counters.
    // Everything but the registers clears at reset, like the block.
    bit [CFG_W-1:0]  width_reg  = CFG_W'(RESET_WIDTH);
    bit [CFG_W-1:0]  height_reg = CFG_W'(RESET_HEIGHT);
    bit [SIDE_W-1:0] src_col;
    bit [SIDE_W-1:0] src_row;
    bit [DCOL_W-1:0] dst_col;
    bit [SIDE_W-1:0] dst_row;
    bit [SIDE_W-1:0] dst_height;
    bit [SIDE_W-1:0] col_tgt;
    bit [SIDE_W-1:0] col_rem;
    bit [SIDE_W-1:0] row_tgt;
    bit [SIDE_W-1:0] row_rem;
    bit [SIDE_W-1:0] row_q;
    bit [SIDE_W-1:0] row_r;

    // Source-side pacing and receiver-side pacing.
    int       burst_left    = 0;
    bit       steady_source = 1'b0;
    int       hold_off_left = 0;
    int       mode_left     = 0;
    rx_pace_t rx_pace       = RX_STEADY;

    // Run statistics.
    int beats_sent     = 0;
    int frames_started = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int error_count    = 0;

    nearest_neighbor_downscaler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predicts what one accepted source beat produces. The width is raised to the
    // output width and both sides are capped at MAX_SIDE. A start beat restarts all
    // counters and works out the output height and the row step from the registers
    // as they stand; the column step always follows the current width register.
    // Returns 1 when the beat is a selected pixel.
    function automatic bit downscale_pixel(input bit start, input bit [PIX_W-1:0] pixel,
                                           output scaled_pixel_t picked);
        int w;
        int h;
        int col_q;
        int col_r;
        bit active;
        bit on_row;
        bit hit;
        picked = '0;
        w = int'(width_reg);
        if (w < OUT_WIDTH)
        begin
            w = OUT_WIDTH;
        end
        if (w > MAX_SIDE)
        begin
            w = MAX_SIDE;
        end
        h = (int'(height_reg) > MAX_SIDE) ? MAX_SIDE : int'(height_reg);
        col_q = w / OUT_WIDTH;
        col_r = w % OUT_WIDTH;

        if (start)
        begin
            src_col    = '0;
            src_row    = '0;
            dst_col    = '0;
            dst_row    = '0;
            col_tgt    = '0;
            col_rem    = '0;
            row_tgt    = '0;
            row_rem    = '0;
            dst_height = SIDE_W'(h * OUT_WIDTH / w);
            if (dst_height != 0)
            begin
                row_q = SIDE_W'(h / int'(dst_height));
                row_r = SIDE_W'(h % int'(dst_height));
            end
            else
            begin
                row_q = '0;
                row_r = '0;
            end
        end

        // Rows count only while output rows remain, so pixels past the frame
        // neither emit nor move the row counter.
        active = dst_row < dst_height;
        on_row = active && src_row == row_tgt;
        hit    = on_row && dst_col < OUT_WIDTH && src_col == col_tgt;

        if (hit)
        begin
            picked.pixel = pixel;
            picked.index = IDX_W'(int'(dst_col) + int'(dst_row) * OUT_WIDTH);
            picked.done  = (int'(dst_row) + 1 == int'(dst_height)) &&
                           (int'(dst_col) + 1 == OUT_WIDTH);
            dst_col = dst_col + 1'b1;
            col_tgt = col_tgt + SIDE_W'(col_q);
            col_rem = col_rem + SIDE_W'(col_r);
            if (col_rem >= OUT_WIDTH)
            begin
                col_rem = col_rem - SIDE_W'(OUT_WIDTH);
                col_tgt = col_tgt + 1'b1;
            end
        end

        // A column at or past the current width closes the row, even if the width
        // shrank in the middle of it.
        if (int'(src_col) + 1 >= w)
        begin
            src_col = '0;
            dst_col = '0;
            col_tgt = '0;
            col_rem = '0;
            if (active)
            begin
                src_row = src_row + 1'b1;
                if (on_row)
                begin
                    dst_row = dst_row + 1'b1;
                    row_tgt = row_tgt + row_q;
                    row_rem = row_rem + row_r;
                    if (row_rem >= dst_height)
                    begin
                        row_rem = row_rem - dst_height;
                        row_tgt = row_tgt + 1'b1;
                    end
                end
            end
        end
        else
        begin
            src_col = src_col + 1'b1;
        end
        return hit;
    endfunction

    // Offers one source beat and waits for it to be taken. The source runs in
    // bursts of random length, and it may drop tvalid between bursts.
    // The prediction is made at the edge where the beat is accepted.
    task automatic send_pixel(input bit start, input bit [PIX_W-1:0] pixel);
        int            gap;
        scaled_pixel_t picked;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = (steady_source || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= pixel;
        do @(posedge clk); while (!s_tready);
        if (downscale_pixel(start, pixel, picked))
        begin
            expected_pixels.push_back(picked);
        end
        beats_sent++;
        if (start)
        begin
            frames_started++;
        end
    endtask

    // Stops the source, waits for every owed pixel, then lets the block go quiet.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one size register once the block is idle and mirrors it.
    task automatic write_size(input logic [REG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_SRC_WIDTH)
        begin
            width_reg = value;
        end
        else
        begin
            height_reg = value;
        end
        reg_writes++;
    endtask

    // Widths: mostly near the output width, some below it, some above 150, up to far beyond the cap.
    function automatic int pick_width();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, OUT_WIDTH - 1);
            1:       return $urandom_range(151, (1 << CFG_W) - 1);
            default: return $urandom_range(OUT_WIDTH, 150);
        endcase
    endfunction

    // Heights: mostly a few rows, now and then zero or at or beyond the cap.
    function automatic int pick_height();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(MAX_SIDE, (1 << CFG_W) - 1);
            2, 3, 4: return 1;
            default: return $urandom_range(2, 3);
        endcase
    endfunction

    // Result side: long random stretches of one pace, or a forced hold-off.
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_pace   = rx_pace_t'($urandom_range(0, 2));
                mode_left = $urandom_range(8, 120);
            end
            mode_left--;
            case (rx_pace)
                RX_STEADY: m_tready <= 1'b1;
                RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Every result beat is matched against the oldest owed pixel, field by field.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_pixels.size() == 0)
            begin
                $error("result beat with nothing owed: out_pixel %h out_index %0d",
                       m_tdata[PIX_W-1:0], m_tdata[PIX_W +: IDX_W]);
                error_count++;
            end
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                check_field("out_pixel", oldest_pixel.pixel, m_tdata[PIX_W-1:0]);
                check_field("out_index", oldest_pixel.index, m_tdata[PIX_W +: IDX_W]);
                check_field("frame_done", oldest_pixel.done, m_tlast);
                check_field("tdata pad", '0, m_tdata >> (PIX_W + IDX_W));
            end
        end
    end

    // Straight after reset no frame has begun, so plain pixels must be dropped.
    task automatic test_no_frame_after_reset();
        repeat (3) send_pixel(1'b0, $urandom);
    endtask

    // One-row output at the minimum width: every source pixel of the first row is
    // copied, so all-zero, all-one and alternating patterns come straight through.
    task automatic test_pixel_extremes();
        write_size(REG_SRC_WIDTH, CFG_W'(OUT_WIDTH));
        write_size(REG_SRC_HEIGHT, CFG_W'(1));
        send_pixel(1'b1, '0);
        send_pixel(1'b0, '1);
        send_pixel(1'b0, 32'hAAAA_AAAA);
        send_pixel(1'b0, 32'h5555_5555);
    endtask

    // A zero height gives an empty output frame.
    task automatic test_zero_height();
        write_size(REG_SRC_HEIGHT, '0);
        send_pixel(1'b1, $urandom);
        repeat (3) send_pixel(1'b0, $urandom);
    endtask

    // A zero width is treated as the output width.
    task automatic test_narrow_width();
        write_size(REG_SRC_WIDTH, '0);
        write_size(REG_SRC_HEIGHT, CFG_W'(2));
        send_pixel(1'b1, $urandom);
        repeat (3) send_pixel(1'b0, $urandom);
    endtask

    // Both registers at their all-ones value are capped at MAX_SIDE.
    task automatic test_oversize_sides();
        write_size(REG_SRC_WIDTH, '1);
        write_size(REG_SRC_HEIGHT, '1);
        send_pixel(1'b1, $urandom);
        repeat (2) send_pixel(1'b0, $urandom);
    endtask

    // Shrinking the width in the middle of a row switches the column step at once
    // while the row plan from the frame start stays.
    task automatic test_mid_frame_resize();
        write_size(REG_SRC_WIDTH, CFG_W'(200));
        write_size(REG_SRC_HEIGHT, CFG_W'(4));
        send_pixel(1'b1, $urandom);
        repeat (5) send_pixel(1'b0, $urandom);
        write_size(REG_SRC_WIDTH, CFG_W'(105));
        repeat (4) send_pixel(1'b0, $urandom);
    endtask

    // The receiver holds off for a long stretch while the source keeps offering a
    // whole one-row frame, so the block fills up and must stall its input.
    task automatic test_backpressure();
        write_size(REG_SRC_WIDTH, CFG_W'(OUT_WIDTH));
        write_size(REG_SRC_HEIGHT, CFG_W'(1));
        steady_source = 1'b1;
        hold_off_left = HOLD_OFF_CYCLES;
        send_pixel(1'b1, $urandom);
        repeat (OUT_WIDTH - 1) send_pixel(1'b0, $urandom);
        steady_source = 1'b0;
    endtask

    // Random frames. Small ones mostly run to the end plus a few pixels past it;
    // others send a random number of beats before the next start beat. Some frames
    // reuse the sizes so the next start arrives while pixels are still in flight,
    // and some get a register rewritten part way through.
    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int plan;
        int split;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            if (sent == 0 || $urandom_range(0, 2) != 0)
            begin
                write_size(REG_SRC_WIDTH, CFG_W'(pick_width()));
                write_size(REG_SRC_HEIGHT, CFG_W'(pick_height()));
            end
            w = int'(width_reg);
            w = (w < OUT_WIDTH) ? OUT_WIDTH : ((w > MAX_SIDE) ? MAX_SIDE : w);
            h = (int'(height_reg) > MAX_SIDE) ? MAX_SIDE : int'(height_reg);
            if (w * h <= 450 && $urandom_range(0, 2) != 0)
            begin
                plan = w * h + $urandom_range(0, 6);
            end
            else
            begin
                plan = $urandom_range(1, 200);
            end
            if (plan > RANDOM_BEATS - sent)
            begin
                plan = RANDOM_BEATS - sent;
            end
            split = (plan > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, plan - 1) : -1;
            for (int i = 0; i < plan; i++)
            begin
                if (i == split)
                begin
                    if ($urandom_range(0, 1) != 0)
                    begin
                        write_size(REG_SRC_WIDTH, CFG_W'(pick_width()));
                    end
                    else
                    begin
                        write_size(REG_SRC_HEIGHT, CFG_W'(pick_height()));
                    end
                end
                send_pixel(i == 0, $urandom);
            end
            sent += plan;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_frame_after_reset();
        test_pixel_extremes();
        test_zero_height();
        test_narrow_width();
        test_oversize_sides();
        test_mid_frame_resize();
        test_backpressure();
        test_random_frames();
        drain_and_settle();

        $display("Downscaled %0d source beats over %0d frame starts and %0d size writes;",
                 beats_sent, frames_started, reg_writes);
        $display("%0d selected pixels were checked on the result stream.", results_seen);
        if (error_count == 0 && expected_pixels.size() == 0)
        begin
            $display("nearest_neighbor_downscaler_test: clean");
        end
        else
        begin
            $display("nearest_neighbor_downscaler_test: errors");
        end
        $finish;
    end

    // Watchdog: a stuck handshake or a missing result ends the run here.
    initial
    begin
        #(RUN_LIMIT_NS * 1ns);
        $display("nearest_neighbor_downscaler_test: errors");
        $finish;
    end

endmodule

@@ nearest_neighbor_downscaler.f @@
+incdir+rtl
rtl/dscl_pkg.sv
rtl/dscl_div.sv
rtl/dscl_front.sv
rtl/dscl_queue.sv
rtl/dscl_back.sv
rtl/nearest_neighbor_downscaler.sv
dv/nearest_neighbor_downscaler_test.sv
